// File: hdl/char_lcd_refresh_scanner_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the character LCD refresh scanner
// Shared property forms, sampled on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef CHAR_LCD_REFRESH_SCANNER_DEFINES_SVH
`define CHAR_LCD_REFRESH_SCANNER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLRS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CLRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/clrs_pkg.sv
// ---------------------------------------------------------------------------
// Character LCD refresh scanner package
// Geometry, display codes and the scan phase type.
// ---------------------------------------------------------------------------
package clrs_pkg;

  // Characters in one display row.
  localparam int ROW_CHARS = 16;

  // Bits to address a column, and bits to count up to a whole row.
  localparam int COL_W = (ROW_CHARS > 1) ? $clog2(ROW_CHARS) : 1;
  localparam int IDX_W = $clog2(ROW_CHARS + 1);

  // Display codes.
  localparam logic [7:0] CURSOR_ROW0 = 8'h80;
  localparam logic [7:0] CURSOR_ROW1 = 8'hC0;
  localparam logic [7:0] BLANK_CHAR  = 8'h20;

  // Request kinds on the input channel.
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Refresh scan phases.
  typedef enum logic [3:0] {
    PH_CURSOR0 = 4'b0001,
    PH_ROW0    = 4'b0010,
    PH_CURSOR1 = 4'b0100,
    PH_ROW1    = 4'b1000
  } scan_phase_t;

endpackage

// File: hdl/char_lcd_refresh_scanner.sv
// A tick request gives its byte on the outputs in the cycle after acceptance.
// Throughput: one request per cycle; writes and ticks alike, set by the single
// result register, which stalls the input only while a byte waits downstream.
// Reset (rst_n low at a clock edge): the frame buffer fills with spaces, the scan
// restarts at the row 0 cursor command and the result register empties.
// ---------------------------------------------------------------------------
// Character LCD refresh scanner
// Two-row frame buffer with a four-phase refresh scan, one display byte per tick.
// ---------------------------------------------------------------------------
`include "char_lcd_refresh_scanner_defines.svh"

module char_lcd_refresh_scanner (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd,
  input  logic       in_row_sel,
  input  logic [3:0] in_column_sel,
  input  logic [7:0] in_char_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_lcd_byte,
  output logic       out_is_data
);

  localparam logic [clrs_pkg::IDX_W-1:0] LAST_IDX =
    clrs_pkg::IDX_W'(clrs_pkg::ROW_CHARS - 1);

  // Frame buffer, scan state and result register.
  logic [7:0]                  fb_r [2][clrs_pkg::ROW_CHARS];
  clrs_pkg::scan_phase_t       phase_r, phase_nxt;
  logic [clrs_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  out_byte_r, out_byte_nxt;
  logic                        out_data_r, out_data_nxt;

  logic                        in_accept;
  logic                        tick;
  logic                        wr_en;
  logic [clrs_pkg::COL_W-1:0]  wr_col;
  logic [clrs_pkg::COL_W-1:0]  rd_col;
  logic                        rd_row;
  logic [7:0]                  rd_char;

  // The input is held only while a byte waits downstream.
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign tick      = in_accept && (in_cmd == clrs_pkg::CMD_TICK);

  // Write port: columns beyond the row are dropped.
  assign wr_en  = in_accept && (in_cmd == clrs_pkg::CMD_WRITE) &&
                  (int'(in_column_sel) < clrs_pkg::ROW_CHARS);
  assign wr_col = clrs_pkg::COL_W'(in_column_sel);

  // Read port follows the scan position.
  assign rd_row  = (phase_r == clrs_pkg::PH_ROW1);
  assign rd_col  = idx_r[clrs_pkg::COL_W-1:0];
  assign rd_char = fb_r[rd_row][rd_col];

  // Scan sequencing and result formation.
  always_comb begin
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    out_byte_nxt  = out_byte_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (tick) begin
      out_valid_nxt = 1'b1;
      case (phase_r)
        clrs_pkg::PH_CURSOR0: begin
          out_byte_nxt = clrs_pkg::CURSOR_ROW0;
          out_data_nxt = 1'b0;
          idx_nxt      = '0;
          phase_nxt    = clrs_pkg::PH_ROW0;
        end
        clrs_pkg::PH_ROW0: begin
          out_byte_nxt = rd_char;
          out_data_nxt = 1'b1;
          idx_nxt      = idx_r + 1'b1;
          if (idx_r == LAST_IDX) begin
            phase_nxt = clrs_pkg::PH_CURSOR1;
          end
        end
        clrs_pkg::PH_CURSOR1: begin
          out_byte_nxt = clrs_pkg::CURSOR_ROW1;
          out_data_nxt = 1'b0;
          idx_nxt      = '0;
          phase_nxt    = clrs_pkg::PH_ROW1;
        end
        clrs_pkg::PH_ROW1: begin
          out_byte_nxt = rd_char;
          out_data_nxt = 1'b1;
          idx_nxt      = idx_r + 1'b1;
          if (idx_r == LAST_IDX) begin
            phase_nxt = clrs_pkg::PH_CURSOR0;
          end
        end
        default: begin
          out_byte_nxt = clrs_pkg::CURSOR_ROW0;
          out_data_nxt = 1'b0;
          idx_nxt      = '0;
          phase_nxt    = clrs_pkg::PH_ROW0;
        end
      endcase
    end
  end

  // Control state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= clrs_pkg::PH_CURSOR0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_data_r <= out_data_nxt;
  end

  // Frame buffer: cleared to spaces at reset, one character written per request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 2; r++) begin
        for (int c = 0; c < clrs_pkg::ROW_CHARS; c++) begin
          fb_r[r][c] <= clrs_pkg::BLANK_CHAR;
        end
      end
    end else if (wr_en) begin
      fb_r[in_row_sel][wr_col] <= in_char_code;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_lcd_byte = out_byte_r;
  assign out_is_data  = out_data_r;

  // Checks on the scan logic.
  `CLRS_ASSERT_NEXT(a_cursor0_next, tick && (phase_r == clrs_pkg::PH_CURSOR0), out_valid && !out_is_data && (out_lcd_byte == clrs_pkg::CURSOR_ROW0), "row 0 cursor tick did not give 0x80")
  `CLRS_ASSERT_SAME(a_cmd_codes, out_valid && !out_is_data, (out_lcd_byte == clrs_pkg::CURSOR_ROW0) || (out_lcd_byte == clrs_pkg::CURSOR_ROW1), "command byte is not a cursor code")
  `CLRS_ASSERT_SAME(a_idx_range, (phase_r == clrs_pkg::PH_ROW0) || (phase_r == clrs_pkg::PH_ROW1), idx_r <= LAST_IDX, "character index beyond the row")
  `CLRS_ASSERT_NEXT(a_write_silent, in_accept && (in_cmd == clrs_pkg::CMD_WRITE) && !in_stall && !(out_valid_r && out_stall), !out_valid, "write request produced a result")

endmodule

// File: dv/tb_char_lcd_refresh_scanner.sv
// ---------------------------------------------------------------------------
// Character LCD refresh scanner testbench
// Drives write and tick requests into the scanner with random gaps on both
// channels, keeps a shadow frame buffer and scan position of its own, and
// compares every display byte with the one that shadow predicts.
// ---------------------------------------------------------------------------
module tb_char_lcd_refresh_scanner;

  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RUN_LIMIT    = 5000000;

  typedef struct packed {
    logic [7:0] lcd_byte;
    logic       is_data;
  } lcd_out_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_cmd;
  logic       in_row_sel;
  logic [3:0] in_column_sel;
  logic [7:0] in_char_code;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_lcd_byte;
  logic       out_is_data;

  // Shadow of the display state, kept in step with accepted requests.
  logic [7:0]            shadow_frame [2][clrs_pkg::ROW_CHARS];
  clrs_pkg::scan_phase_t shadow_phase;
  int unsigned           shadow_index;
  lcd_out_t              pending_bytes [$];

  int unsigned error_count;
  bit          tx_quiet;
  bit          rx_quiet;
  bit          long_hold_req;

  char_lcd_refresh_scanner u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_row_sel   (in_row_sel),
    .in_column_sel(in_column_sel),
    .in_char_code (in_char_code),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_lcd_byte (out_lcd_byte),
    .out_is_data  (out_is_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Guard against a hung run.
  initial begin
    #(RUN_LIMIT);
    $display("char_lcd_refresh_scanner test failed");
    $finish;
  end

  // Prints one line per mismatch and keeps the count.
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
  endtask

  // Advances the shadow scan by one tick and returns the byte it sends.
  function lcd_out_t scan_next_byte();
    lcd_out_t    sent;
    int unsigned col;
    col = (shadow_index < clrs_pkg::ROW_CHARS) ? shadow_index : clrs_pkg::ROW_CHARS - 1;
    case (shadow_phase)
      clrs_pkg::PH_CURSOR0: begin
        sent = {clrs_pkg::CURSOR_ROW0, 1'b0};
        shadow_index = 0;
        shadow_phase = clrs_pkg::PH_ROW0;
      end
      clrs_pkg::PH_ROW0: begin
        sent = {shadow_frame[0][col], 1'b1};
        shadow_index++;
        if (shadow_index >= clrs_pkg::ROW_CHARS) shadow_phase = clrs_pkg::PH_CURSOR1;
      end
      clrs_pkg::PH_CURSOR1: begin
        sent = {clrs_pkg::CURSOR_ROW1, 1'b0};
        shadow_index = 0;
        shadow_phase = clrs_pkg::PH_ROW1;
      end
      default: begin
        sent = {shadow_frame[1][col], 1'b1};
        shadow_index++;
        if (shadow_index >= clrs_pkg::ROW_CHARS) shadow_phase = clrs_pkg::PH_CURSOR0;
      end
    endcase
    return sent;
  endfunction

  // Tracks accepted requests and checks each display byte taken downstream.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 2; r++) begin
        for (int c = 0; c < clrs_pkg::ROW_CHARS; c++) begin
          shadow_frame[r][c] = clrs_pkg::BLANK_CHAR;
        end
      end
      shadow_phase = clrs_pkg::PH_CURSOR0;
      shadow_index = 0;
      pending_bytes.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (in_cmd == clrs_pkg::CMD_WRITE) begin
          if (in_column_sel < clrs_pkg::ROW_CHARS)
            shadow_frame[in_row_sel][in_column_sel] = in_char_code;
        end else begin
          pending_bytes.push_back(scan_next_byte());
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_bytes.size() == 0) begin
          report_mismatch("display byte with none expected", 32'(out_lcd_byte), 0);
        end else begin
          if (out_lcd_byte !== pending_bytes[0].lcd_byte)
            report_mismatch("lcd_byte", 32'(out_lcd_byte),
                            32'(pending_bytes[0].lcd_byte));
          if (out_is_data !== pending_bytes[0].is_data)
            report_mismatch("is_data", 32'(out_is_data),
                            32'(pending_bytes[0].is_data));
          void'(pending_bytes.pop_front());
        end
      end
    end
  end

  // Downstream side: stalls for a random count before each byte, or for a
  // long stretch when a hold-off is requested.
  initial begin : display_sink
    int unsigned wait_cycles;
    out_stall <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        wait_cycles   = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        wait_cycles = rx_quiet ? 0 : $urandom_range(0, 14);
      end
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offers one request after a random gap and holds it until it is taken.
  task automatic send_request(input logic cmd, input logic row,
                              input logic [3:0] col, input logic [7:0] chr);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_row_sel    <= row;
    in_column_sel <= col;
    in_char_code  <= chr;
    do @(posedge clk); while (in_stall);
  endtask

  // Bursts of writes or ticks with random content; idling optional.
  task automatic send_random_bursts(input int unsigned n_items, input bit allow_idle);
    int unsigned sent;
    int unsigned burst;
    logic        kind;
    sent = 0;
    while (sent < n_items) begin
      kind  = $urandom_range(0, 1) ? clrs_pkg::CMD_WRITE : clrs_pkg::CMD_TICK;
      burst = $urandom_range(1, 40);
      tx_quiet = !allow_idle || ($urandom_range(0, 3) == 0);
      rx_quiet = !allow_idle || ($urandom_range(0, 3) == 0);
      repeat (burst) begin
        send_request(kind, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                     8'($urandom_range(0, 255)));
        sent++;
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // Extreme characters and corners, the row 0 pass, writes made mid-scan
  // both ahead of and behind the scan, and ticks carrying stray fields.
  task automatic test_directed_scan();
    send_request(clrs_pkg::CMD_WRITE, 1'b0, 4'd0,  8'h00);
    send_request(clrs_pkg::CMD_WRITE, 1'b1, 4'd15, 8'hFF);
    send_request(clrs_pkg::CMD_WRITE, 1'b0, 4'd15, 8'h7E);
    send_request(clrs_pkg::CMD_WRITE, 1'b1, 4'd0,  8'h41);
    send_request(clrs_pkg::CMD_TICK,  1'b1, 4'd15, 8'hFF);
    send_request(clrs_pkg::CMD_TICK,  1'b0, 4'd0,  8'h00);
    send_request(clrs_pkg::CMD_TICK,  1'b1, 4'd9,  8'hAA);
    send_request(clrs_pkg::CMD_WRITE, 1'b0, 4'd5,  8'hA5);
    send_request(clrs_pkg::CMD_WRITE, 1'b0, 4'd0,  8'h5A);
    repeat (15) begin
      send_request(clrs_pkg::CMD_TICK, 1'($urandom_range(0, 1)),
                   4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    end
  endtask

  // Mixed traffic with random idling on both channels.
  task automatic test_random_traffic();
    send_random_bursts(1050, 1'b1);
  endtask

  // Requests every cycle with the receiver always ready.
  task automatic test_back_to_back();
    send_random_bursts(150, 1'b0);
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_receiver_hold_off();
    long_hold_req = 1'b1;
    tx_quiet      = 1'b1;
    repeat (120) begin
      send_request(($urandom_range(0, 3) == 0) ? clrs_pkg::CMD_WRITE : clrs_pkg::CMD_TICK,
                   1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                   8'($urandom_range(0, 255)));
    end
    tx_quiet = 1'b0;
  endtask

  // Reset, the test sequence and the final verdict.
  initial begin
    error_count   = 0;
    tx_quiet      = 1'b0;
    rx_quiet      = 1'b0;
    long_hold_req = 1'b0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_cmd        <= clrs_pkg::CMD_TICK;
    in_row_sel    <= 1'b0;
    in_column_sel <= 4'd0;
    in_char_code  <= 8'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_scan();
    test_random_traffic();
    test_back_to_back();
    test_receiver_hold_off();
    in_valid <= 1'b0;

    // Let the checker record the last accepted request before draining.
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("char_lcd_refresh_scanner test passed");
    end else begin
      $display("char_lcd_refresh_scanner test failed");
    end
    $finish;
  end

endmodule
